// ===== sv/kmc_pkg.sv =====
// shared types and constants of the k-means clustering engine
package kmc_pkg;

    localparam int COORD_W      = 16;
    localparam int NUM_DIMS     = 3;
    localparam int MAX_CLUSTERS = 8;
    localparam int CIDX_W       = 3;
    localparam int DIM_W        = 2;
    localparam int KCNT_W       = 4;
    localparam int PASS_W       = 5;
    localparam int PASS_LIMIT   = 16;
    localparam int MODE_W       = 2;
    localparam int COUNT_OUT_W  = 11;
    localparam int DIST_W       = 27;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int QUEUE_DEPTH  = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;

    localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

    // input modes
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT    = 1'd1;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SET,
        OP_CLEAR,
        OP_RUN
    } item_op_t;

    typedef struct packed {
        item_op_t                  op;
        logic [CIDX_W-1:0]         idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } item_t;

endpackage

// ===== sv/kmc_if.sv =====
// channel interfaces of the k-means clustering engine
interface kmc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [kmc_pkg::MODE_W-1:0]            mode;
    logic [kmc_pkg::CIDX_W-1:0]            centroid_index;
    logic signed [kmc_pkg::COORD_W-1:0]    coord_x;
    logic signed [kmc_pkg::COORD_W-1:0]    coord_y;
    logic signed [kmc_pkg::COORD_W-1:0]    coord_z;

    modport source (output valid, mode, centroid_index, coord_x, coord_y, coord_z,
                    input ready);
    modport sink (input valid, mode, centroid_index, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface kmc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [kmc_pkg::CIDX_W-1:0]            cluster_id;
    logic signed [kmc_pkg::COORD_W-1:0]    mean_x;
    logic signed [kmc_pkg::COORD_W-1:0]    mean_y;
    logic signed [kmc_pkg::COORD_W-1:0]    mean_z;
    logic [kmc_pkg::COUNT_OUT_W-1:0]       member_count;
    logic [kmc_pkg::DIST_W-1:0]            set_distance;
    logic                                  last;

    modport source (output valid, cluster_id, mean_x, mean_y, mean_z, member_count,
                    set_distance, last, input ready);
    modport sink (input valid, cluster_id, mean_x, mean_y, mean_z, member_count,
                  set_distance, last, output ready);
endinterface

// ===== sv/kmc_queue.sv =====
// short item queue between the front end and the execution back end
module kmc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kmc_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output kmc_pkg::item_t head,
    output logic           head_valid
);

    localparam int PTR_W = $clog2(kmc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(kmc_pkg::QUEUE_DEPTH + 1);

    kmc_pkg::item_t   entry_reg [kmc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(kmc_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== sv/kmc_exec.sv =====
// execution back end: point store, assignment passes, mean update and report
module kmc_exec
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  kmc_pkg::item_t                head,
    input  logic                          head_valid,
    output logic                          head_pop,
    input  logic [kmc_pkg::KCNT_W-1:0]    k_in,
    input  logic [kmc_pkg::PASS_W-1:0]    passes_in,
    kmc_out_if.source                     out_ch
);

    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW     = $clog2(MAX_POINTS + 1);
    localparam int SW     = kmc_pkg::COORD_W + CW;
    localparam int STEP_W = $clog2(SW);
    localparam int CRD    = kmc_pkg::COORD_W;
    localparam int ND     = kmc_pkg::NUM_DIMS;
    localparam int NC     = kmc_pkg::MAX_CLUSTERS;
    localparam int SQW    = kmc_pkg::SQ_W;
    localparam int PW     = ND * CRD;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PASS_INIT,
        ST_FETCH,
        ST_SQ,
        ST_ACC,
        ST_ASSIGN,
        ST_UPD_CHK,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DIV_END,
        ST_REP_INIT,
        ST_RFETCH,
        ST_RCHK,
        ST_SQRT,
        ST_SACC,
        ST_EMIT
    } state_t;

    // memories
    logic [PW-1:0]                  pmem [MAX_POINTS];
    logic [kmc_pkg::CIDX_W-1:0]     amem [MAX_POINTS];
    logic [PW-1:0]                  pt_q;
    logic [kmc_pkg::CIDX_W-1:0]     asg_q;

    state_t                         state_reg;
    logic [CW-1:0]                  n_reg;
    logic [AW-1:0]                  p_reg;
    logic [kmc_pkg::CIDX_W-1:0]     c_reg;
    logic [kmc_pkg::DIM_W-1:0]      d_reg;
    logic [SQW-1:0]                 acc_reg;
    logic [SQW-1:0]                 sq_reg;
    logic [SQW-1:0]                 best_reg;
    logic [kmc_pkg::CIDX_W-1:0]     bidx_reg;
    logic [kmc_pkg::KCNT_W-1:0]     k_reg;
    logic [kmc_pkg::PASS_W-1:0]     passes_reg;
    logic [kmc_pkg::PASS_W-1:0]     pass_reg;
    logic                           rep_reg;
    logic signed [CRD-1:0]          cen_reg [NC][ND];
    logic signed [SW-1:0]           sum_reg [NC][ND];
    logic [CW-1:0]                  cnt_reg [NC];
    logic [CW:0]                    rem_reg;
    logic [SW-1:0]                  quo_reg;
    logic [STEP_W-1:0]              step_reg;
    logic                           neg_reg;
    logic [SQW-1:0]                 v_reg;
    logic [SQW-1:0]                 res_reg;
    logic [SQW-1:0]                 bit_reg;
    logic [kmc_pkg::DIST_W-1:0]     dsum_reg;
    logic                           out_valid_reg;
    logic [kmc_pkg::CIDX_W-1:0]     out_id_reg;
    logic signed [CRD-1:0]          out_mean_reg [ND];
    logic [kmc_pkg::COUNT_OUT_W-1:0] out_cnt_reg;
    logic [kmc_pkg::DIST_W-1:0]     out_dist_reg;
    logic                           out_last_reg;

    logic signed [CRD-1:0]          pt_c [ND];
    logic signed [kmc_pkg::DIFF_W-1:0] diff;
    logic signed [SQW-1:0]          prod;
    logic [SQW-1:0]                 sq_sum;
    logic                           last_dim;
    logic                           last_cluster;
    logic                           last_point;
    logic                           load_we;
    logic                           asg_we;
    logic [CW:0]                    rem_shift;
    logic                           rem_ge;
    logic [SW-1:0]                  sum_mag;
    logic signed [CRD-1:0]          quo_s;
    logic [SQW-1:0]                 trial;
    logic                           sq_ge;
    logic [kmc_pkg::DIST_W:0]       dsum_wide;
    logic [CW+kmc_pkg::COUNT_OUT_W-1:0] cnt_wide;
    logic                           emit_ok;
    logic                           emit_fire;

    always_comb
    begin
        for (int d = 0; d < ND; d++)
        begin
            pt_c[d] = pt_q[d*CRD +: CRD];
        end
    end

    assign diff = {pt_c[d_reg][CRD-1], pt_c[d_reg]}
                - {cen_reg[c_reg][d_reg][CRD-1], cen_reg[c_reg][d_reg]};
    assign prod = diff * diff;
    assign sq_sum = acc_reg + sq_reg;

    assign last_dim     = (d_reg == kmc_pkg::DIM_W'(ND - 1));
    assign last_cluster = ({1'b0, c_reg} == k_reg - 1'b1);
    assign last_point   = (CW'(p_reg) == n_reg - 1'b1);

    assign head_pop = (state_reg == ST_IDLE) && head_valid;
    assign load_we  = head_pop && (head.op == kmc_pkg::OP_LOAD)
                   && (n_reg != CW'(MAX_POINTS));
    assign asg_we   = (state_reg == ST_ASSIGN);

    // restoring divider step
    assign rem_shift = {rem_reg[CW-1:0], quo_reg[SW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, cnt_reg[c_reg]});
    assign sum_mag   = sum_reg[c_reg][d_reg][SW-1] ? SW'(-sum_reg[c_reg][d_reg])
                                                  : SW'(sum_reg[c_reg][d_reg]);
    assign quo_s     = neg_reg ? -$signed(quo_reg[CRD-1:0]) : $signed(quo_reg[CRD-1:0]);

    // digit-by-digit square root step
    assign trial = res_reg + bit_reg;
    assign sq_ge = (v_reg >= trial);

    assign dsum_wide = {1'b0, dsum_reg} + (kmc_pkg::DIST_W + 1)'(res_reg);
    assign cnt_wide  = (CW + kmc_pkg::COUNT_OUT_W)'(cnt_reg[c_reg]);
    assign emit_ok   = !out_valid_reg || out_ch.ready;
    assign emit_fire = (state_reg == ST_EMIT) && emit_ok;

    // point and assignment memories
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            pmem[n_reg[AW-1:0]] <= {head.z, head.y, head.x};
        end
        if (asg_we)
        begin
            amem[p_reg] <= bidx_reg;
        end
        pt_q  <= pmem[p_reg];
        asg_q <= amem[p_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            p_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            acc_reg       <= '0;
            sq_reg        <= '0;
            best_reg      <= '0;
            bidx_reg      <= '0;
            k_reg         <= '0;
            passes_reg    <= '0;
            pass_reg      <= '0;
            rep_reg       <= 1'b0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            step_reg      <= '0;
            neg_reg       <= 1'b0;
            v_reg         <= '0;
            res_reg       <= '0;
            bit_reg       <= '0;
            dsum_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_id_reg    <= '0;
            out_cnt_reg   <= '0;
            out_dist_reg  <= '0;
            out_last_reg  <= 1'b0;
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= '0;
                for (int d = 0; d < ND; d++)
                begin
                    cen_reg[i][d] <= '0;
                    sum_reg[i][d] <= '0;
                end
            end
            for (int d = 0; d < ND; d++)
            begin
                out_mean_reg[d] <= '0;
            end
        end
        else
        begin
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid)
                    begin
                        unique case (head.op)
                            kmc_pkg::OP_LOAD:
                            begin
                                if (load_we)
                                begin
                                    n_reg <= n_reg + 1'b1;
                                end
                            end
                            kmc_pkg::OP_SET:
                            begin
                                cen_reg[head.idx][0] <= head.x;
                                cen_reg[head.idx][1] <= head.y;
                                cen_reg[head.idx][2] <= head.z;
                            end
                            kmc_pkg::OP_CLEAR:
                            begin
                                n_reg <= '0;
                            end
                            kmc_pkg::OP_RUN:
                            begin
                                k_reg      <= k_in;
                                passes_reg <= passes_in;
                                pass_reg   <= '0;
                                rep_reg    <= 1'b0;
                                state_reg  <= ST_PASS_INIT;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end

                ST_PASS_INIT:
                begin
                    for (int i = 0; i < NC; i++)
                    begin
                        cnt_reg[i] <= '0;
                        for (int d = 0; d < ND; d++)
                        begin
                            sum_reg[i][d] <= '0;
                        end
                    end
                    p_reg <= '0;
                    c_reg <= '0;
                    d_reg <= '0;
                    acc_reg <= '0;
                    state_reg <= (n_reg == '0) ? ST_UPD_CHK : ST_FETCH;
                end

                ST_FETCH:
                begin
                    c_reg     <= '0;
                    d_reg     <= '0;
                    acc_reg   <= '0;
                    state_reg <= ST_SQ;
                end

                ST_SQ:
                begin
                    sq_reg    <= SQW'(unsigned'(prod));
                    state_reg <= ST_ACC;
                end

                ST_ACC:
                begin
                    if (!last_dim)
                    begin
                        acc_reg   <= sq_sum;
                        d_reg     <= d_reg + 1'b1;
                        state_reg <= ST_SQ;
                    end
                    else if (rep_reg)
                    begin
                        v_reg     <= sq_sum;
                        res_reg   <= '0;
                        bit_reg   <= SQW'(1) << (SQW - 2);
                        state_reg <= ST_SQRT;
                    end
                    else
                    begin
                        // strict compare keeps the lower index on a tie
                        if (c_reg == '0 || sq_sum < best_reg)
                        begin
                            best_reg <= sq_sum;
                            bidx_reg <= c_reg;
                        end
                        acc_reg <= '0;
                        d_reg   <= '0;
                        if (last_cluster)
                        begin
                            state_reg <= ST_ASSIGN;
                        end
                        else
                        begin
                            c_reg     <= c_reg + 1'b1;
                            state_reg <= ST_SQ;
                        end
                    end
                end

                ST_ASSIGN:
                begin
                    cnt_reg[bidx_reg] <= cnt_reg[bidx_reg] + 1'b1;
                    for (int d = 0; d < ND; d++)
                    begin
                        sum_reg[bidx_reg][d] <= sum_reg[bidx_reg][d]
                            + {{(SW-CRD){pt_c[d][CRD-1]}}, pt_c[d]};
                    end
                    if (last_point)
                    begin
                        c_reg     <= '0;
                        state_reg <= ST_UPD_CHK;
                    end
                    else
                    begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_FETCH;
                    end
                end

                ST_UPD_CHK:
                begin
                    d_reg <= '0;
                    if (cnt_reg[c_reg] != '0)
                    begin
                        state_reg <= ST_DIV_LOAD;
                    end
                    else if (!last_cluster)
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                    else if (pass_reg == passes_reg - 1'b1)
                    begin
                        c_reg     <= '0;
                        rep_reg   <= 1'b1;
                        state_reg <= ST_REP_INIT;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= ST_PASS_INIT;
                    end
                end

                ST_DIV_LOAD:
                begin
                    neg_reg   <= sum_reg[c_reg][d_reg][SW-1];
                    quo_reg   <= sum_mag;
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    rem_reg  <= rem_ge ? (rem_shift - {1'b0, cnt_reg[c_reg]}) : rem_shift;
                    quo_reg  <= {quo_reg[SW-2:0], rem_ge};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SW - 1))
                    begin
                        state_reg <= ST_DIV_END;
                    end
                end

                ST_DIV_END:
                begin
                    cen_reg[c_reg][d_reg] <= quo_s;
                    if (!last_dim)
                    begin
                        d_reg     <= d_reg + 1'b1;
                        state_reg <= ST_DIV_LOAD;
                    end
                    else if (!last_cluster)
                    begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= ST_UPD_CHK;
                    end
                    else if (pass_reg == passes_reg - 1'b1)
                    begin
                        c_reg     <= '0;
                        rep_reg   <= 1'b1;
                        state_reg <= ST_REP_INIT;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= ST_PASS_INIT;
                    end
                end

                ST_REP_INIT:
                begin
                    p_reg     <= '0;
                    dsum_reg  <= '0;
                    state_reg <= (n_reg == '0) ? ST_EMIT : ST_RFETCH;
                end

                ST_RFETCH:
                begin
                    state_reg <= ST_RCHK;
                end

                ST_RCHK:
                begin
                    d_reg   <= '0;
                    acc_reg <= '0;
                    if (asg_q == c_reg)
                    begin
                        state_reg <= ST_SQ;
                    end
                    else if (last_point)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_RFETCH;
                    end
                end

                ST_SQRT:
                begin
                    if (sq_ge)
                    begin
                        v_reg   <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0])
                    begin
                        state_reg <= ST_SACC;
                    end
                end

                ST_SACC:
                begin
                    dsum_reg <= (dsum_wide > (kmc_pkg::DIST_W + 1)'(kmc_pkg::DIST_SAT))
                              ? kmc_pkg::DIST_SAT : dsum_wide[kmc_pkg::DIST_W-1:0];
                    if (last_point)
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_RFETCH;
                    end
                end

                ST_EMIT:
                begin
                    if (emit_ok)
                    begin
                        out_id_reg    <= c_reg;
                        for (int d = 0; d < ND; d++)
                        begin
                            out_mean_reg[d] <= cen_reg[c_reg][d];
                        end
                        out_cnt_reg  <= cnt_wide[kmc_pkg::COUNT_OUT_W-1:0];
                        out_dist_reg <= dsum_reg;
                        out_last_reg <= last_cluster;
                        if (last_cluster)
                        begin
                            rep_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            c_reg     <= c_reg + 1'b1;
                            state_reg <= ST_REP_INIT;
                        end
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.cluster_id   = out_id_reg;
    assign out_ch.mean_x       = out_mean_reg[0];
    assign out_ch.mean_y       = out_mean_reg[1];
    assign out_ch.mean_z       = out_mean_reg[2];
    assign out_ch.member_count = out_cnt_reg;
    assign out_ch.set_distance = out_dist_reg;
    assign out_ch.last         = out_last_reg;

endmodule

// ===== sv/kmeans_cluster_engine.sv =====
// top level of the k-means clustering engine
// Lloyd k-means over up to MAX_POINTS 3-D points with 16-bit signed coordinates.
// The front end takes one input beat per cycle, while the queue is not full,
// into a four-entry queue; the back end drains it. Loads, centroid writes and
// clears are handled in the back end's idle state. A run holds the back end
// until its last report beat is in the output register (input stalls once the
// queue fills). A cluster sum is SW = 16 + clog2(MAX_POINTS+1) bits wide.
// A run's length is set by the single shared squarer, the bit-serial mean
// divider (one quotient bit a cycle) and the 17-step square-root unit. Points
// and per-point cluster tags live in RAMs with one read and one write port,
// read one entry a cycle.
// Result beats leave through an output register, so a run's report can wait
// on a stalled sink without losing anything.
module kmeans_cluster_engine
#(
    parameter int MAX_POINTS = 1024
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    kmc_in_if.sink                            in_ch,
    kmc_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [kmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [kmc_pkg::KCNT_W-1:0] cluster_count_reg;
    logic [kmc_pkg::PASS_W-1:0] pass_count_reg;
    logic [kmc_pkg::KCNT_W-1:0] k_eff;
    logic [kmc_pkg::PASS_W-1:0] passes_eff;

    kmc_pkg::item_t push_item;
    kmc_pkg::item_t head;
    logic           q_full;
    logic           push;
    logic           head_valid;
    logic           head_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= kmc_pkg::KCNT_W'(2);
            pass_count_reg    <= kmc_pkg::PASS_W'(10);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                kmc_pkg::REG_CLUSTER_COUNT: cluster_count_reg <= cfg_data[kmc_pkg::KCNT_W-1:0];
                kmc_pkg::REG_PASS_COUNT:    pass_count_reg    <= cfg_data;
                default:                    cluster_count_reg <= cluster_count_reg;
            endcase
        end
    end

    // clamp the settings into their usable ranges
    always_comb
    begin
        if (cluster_count_reg == '0)
        begin
            k_eff = kmc_pkg::KCNT_W'(1);
        end
        else if (cluster_count_reg > kmc_pkg::KCNT_W'(kmc_pkg::MAX_CLUSTERS))
        begin
            k_eff = kmc_pkg::KCNT_W'(kmc_pkg::MAX_CLUSTERS);
        end
        else
        begin
            k_eff = cluster_count_reg;
        end

        if (pass_count_reg == '0)
        begin
            passes_eff = kmc_pkg::PASS_W'(1);
        end
        else if (pass_count_reg > kmc_pkg::PASS_W'(kmc_pkg::PASS_LIMIT))
        begin
            passes_eff = kmc_pkg::PASS_W'(kmc_pkg::PASS_LIMIT);
        end
        else
        begin
            passes_eff = pass_count_reg;
        end
    end

    // front end: take a beat, decode its mode into an operation
    assign in_ch.ready = !q_full;
    assign push        = in_ch.valid && !q_full;

    always_comb
    begin
        push_item.idx = in_ch.centroid_index;
        push_item.x   = in_ch.coord_x;
        push_item.y   = in_ch.coord_y;
        push_item.z   = in_ch.coord_z;
        unique case (in_ch.mode)
            kmc_pkg::MODE_LOAD:  push_item.op = kmc_pkg::OP_LOAD;
            kmc_pkg::MODE_SET:   push_item.op = kmc_pkg::OP_SET;
            kmc_pkg::MODE_CLEAR: push_item.op = kmc_pkg::OP_CLEAR;
            kmc_pkg::MODE_RUN:   push_item.op = kmc_pkg::OP_RUN;
            default:             push_item.op = kmc_pkg::OP_LOAD;
        endcase
    end

    kmc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (head_pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // back end: storage, clustering passes and the per-cluster report
    kmc_exec #(.MAX_POINTS(MAX_POINTS)) u_exec
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .k_in       (k_eff),
        .passes_in  (passes_eff),
        .out_ch     (out_ch)
    );

endmodule

// ===== tb/kmeans_cluster_engine_tb.sv =====
// testbench of the k-means clustering engine: directed table, then random sequences vs predictor
`timescale 1ns / 1ps

module kmeans_cluster_engine_tb;

    localparam int STORE_DEPTH = 1024;
    localparam int ITEM_GOAL   = 400;

    // one result beat as the output channel carries it
    typedef struct packed {
        logic [kmc_pkg::CIDX_W-1:0]         id;
        logic signed [kmc_pkg::COORD_W-1:0] mx;
        logic signed [kmc_pkg::COORD_W-1:0] my;
        logic signed [kmc_pkg::COORD_W-1:0] mz;
        logic [kmc_pkg::COUNT_OUT_W-1:0]    members;
        logic [kmc_pkg::DIST_W-1:0]         dist_sum;
        logic                               last;
    } report_t;

    // directed row: typed count of -1 means the predictor supplies the reports
    typedef struct {
        kmc_pkg::item_t it;
        int             typed;
        report_t        exp0;
        report_t        exp1;
    } row_t;

    logic clk;
    logic rst_n;
    logic                           cfg_we;
    logic [kmc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [kmc_pkg::CFG_DATA_W-1:0] cfg_data;

    kmc_in_if  in_ch ();
    kmc_out_if out_ch ();

    kmeans_cluster_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state, a mirror of the engine's stores
    int            pts [STORE_DEPTH][3];
    int unsigned   npts;
    int            cents [kmc_pkg::MAX_CLUSTERS][3];
    bit [2:0]      tags [STORE_DEPTH];
    int unsigned   members [kmc_pkg::MAX_CLUSTERS];
    longint        sums [kmc_pkg::MAX_CLUSTERS][3];
    bit [kmc_pkg::KCNT_W-1:0] cfg_k;
    bit [kmc_pkg::PASS_W-1:0] cfg_passes;

    report_t expected_reports [$];
    report_t fresh_reports [$];

    int idle_pct;
    int stall_pct;
    int mismatches;
    int reports_seen;
    int items_sent;
    int runs_sent;

    // floor square root, bit by bit
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned point_dist2(int p, int c);
        longint unsigned s;
        longint diff;
        s = 0;
        for (int d = 0; d < 3; d++)
        begin
            diff = longint'(pts[p][d]) - longint'(cents[c][d]);
            if (diff < 0)
                diff = -diff;
            s += longint'(diff) * longint'(diff);
        end
        return s;
    endfunction

    function automatic void lloyd_pass(int k);
        int best;
        longint unsigned bd;
        longint unsigned dd;
        for (int c = 0; c < kmc_pkg::MAX_CLUSTERS; c++)
        begin
            members[c] = 0;
            for (int d = 0; d < 3; d++)
                sums[c][d] = 0;
        end
        for (int p = 0; p < npts; p++)
        begin
            best = 0;
            bd = point_dist2(p, 0);
            for (int c = 1; c < k; c++)
            begin
                dd = point_dist2(p, c);
                // strict compare keeps the lower index on a tie
                if (dd < bd)
                begin
                    bd = dd;
                    best = c;
                end
            end
            tags[p] = best[2:0];
            members[best]++;
            for (int d = 0; d < 3; d++)
                sums[best][d] += pts[p][d];
        end
        for (int c = 0; c < k; c++)
            if (members[c] != 0)
                for (int d = 0; d < 3; d++)
                    cents[c][d] = int'(sums[c][d] / longint'(members[c]));
    endfunction

    // applies one accepted item; a run leaves its reports in fresh_reports
    function automatic void cluster_predict(kmc_pkg::item_t it);
        int k;
        int passes;
        longint unsigned acc;
        report_t r;
        fresh_reports.delete();
        case (it.op)
            kmc_pkg::OP_LOAD:
            begin
                if (npts < STORE_DEPTH)
                begin
                    pts[npts][0] = it.x;
                    pts[npts][1] = it.y;
                    pts[npts][2] = it.z;
                    npts++;
                end
            end
            kmc_pkg::OP_SET:
            begin
                cents[it.idx][0] = it.x;
                cents[it.idx][1] = it.y;
                cents[it.idx][2] = it.z;
            end
            kmc_pkg::OP_CLEAR:
                npts = 0;
            default:
            begin
                k = (cfg_k < 1) ? 1 :
                    (cfg_k > kmc_pkg::MAX_CLUSTERS) ? kmc_pkg::MAX_CLUSTERS : int'(cfg_k);
                passes = (cfg_passes < 1) ? 1 :
                         (cfg_passes > kmc_pkg::PASS_LIMIT) ? kmc_pkg::PASS_LIMIT
                                                             : int'(cfg_passes);
                for (int i = 0; i < passes; i++)
                    lloyd_pass(k);
                for (int c = 0; c < k; c++)
                begin
                    acc = 0;
                    for (int p = 0; p < npts; p++)
                        if (tags[p] == c)
                        begin
                            acc += root_floor(point_dist2(p, c));
                            if (acc > kmc_pkg::DIST_SAT)
                                acc = kmc_pkg::DIST_SAT;
                        end
                    r.id       = c[2:0];
                    r.mx       = cents[c][0][15:0];
                    r.my       = cents[c][1][15:0];
                    r.mz       = cents[c][2][15:0];
                    r.members  = members[c][10:0];
                    r.dist_sum = acc[26:0];
                    r.last     = (c + 1 == k);
                    fresh_reports.push_back(r);
                end
            end
        endcase
    endfunction

    function automatic kmc_pkg::item_t make_item(kmc_pkg::item_op_t op, int idx, int x,
                                                 int y, int z);
        kmc_pkg::item_t it;
        it.op  = op;
        it.idx = idx[2:0];
        it.x   = x[15:0];
        it.y   = y[15:0];
        it.z   = z[15:0];
        return it;
    endfunction

    function automatic report_t make_report(int id, int x, int y, int z, int n, int dsum,
                                            bit last);
        report_t r;
        r.id = id[2:0];
        r.mx = x[15:0];
        r.my = y[15:0];
        r.mz = z[15:0];
        r.members = n[10:0];
        r.dist_sum = dsum[26:0];
        r.last = last;
        return r;
    endfunction

    // drives one item and waits for its beat; returns in the step of acceptance
    task automatic push_item(kmc_pkg::item_t it);
        if ($urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.mode           <= it.op;
        in_ch.centroid_index <= it.idx;
        in_ch.coord_x        <= it.x;
        in_ch.coord_y        <= it.y;
        in_ch.coord_z        <= it.z;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        if (it.op == kmc_pkg::OP_RUN)
            runs_sent++;
    endtask

    task automatic send_predicted(kmc_pkg::item_t it);
        push_item(it);
        cluster_predict(it);
        foreach (fresh_reports[i])
            expected_reports.push_back(fresh_reports[i]);
    endtask

    // lets the engine drain: every report back, then queued non-report items
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [kmc_pkg::CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[kmc_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == kmc_pkg::REG_CLUSTER_COUNT)
            cfg_k = value[kmc_pkg::KCNT_W-1:0];
        else
            cfg_passes = value[kmc_pkg::PASS_W-1:0];
    endtask

    function automatic int pick_coord();
        case ($urandom_range(5))
            0: return -32768;
            1: return 32767;
            2: return 0;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int near(int center);
        int v;
        v = center + int'($urandom_range(0, 2000)) - 1000;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // result side: random backpressure and the compare against the oldest expectation
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.id       = out_ch.cluster_id;
            got.mx       = out_ch.mean_x;
            got.my       = out_ch.mean_y;
            got.mz       = out_ch.mean_z;
            got.members  = out_ch.member_count;
            got.dist_sum = out_ch.set_distance;
            got.last     = out_ch.last;
            reports_seen++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: id %0d mean %0d %0d %0d n %0d dist %0d last %0b",
                             got.id, got.mx, got.my, got.mz, got.members, got.dist_sum,
                             got.last);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.id !== want.id || got.mx !== want.mx || got.my !== want.my ||
                    got.mz !== want.mz || got.members !== want.members ||
                    got.dist_sum !== want.dist_sum || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp: id %0d mean %0d %0d %0d n %0d dist %0d last %0b",
                                 want.id, want.mx, want.my, want.mz, want.members,
                                 want.dist_sum, want.last);
                        $display("         got: id %0d mean %0d %0d %0d n %0d dist %0d last %0b",
                                 got.id, got.mx, got.my, got.mz, got.members,
                                 got.dist_sum, got.last);
                    end
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #400_000_000;
        $display("kmeans_cluster_engine_tb: FAIL");
        $finish;
    end

    initial
    begin
        row_t rows [$];
        row_t row;
        int k_eff;
        int n_new;
        int cx, cy, cz;
        int seq;

        rst_n = 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.mode <= kmc_pkg::MODE_LOAD;
        in_ch.centroid_index <= '0;
        in_ch.coord_x <= '0;
        in_ch.coord_y <= '0;
        in_ch.coord_z <= '0;
        out_ch.ready <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= kmc_pkg::REG_CLUSTER_COUNT;
        cfg_data <= '0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        reports_seen = 0;
        items_sent = 0;
        runs_sent = 0;

        // predictor reset: stores zero, two clusters, ten passes
        npts = 0;
        foreach (cents[c, d])
            cents[c][d] = 0;
        foreach (tags[p])
            tags[p] = '0;
        cfg_k = 4'd2;
        cfg_passes = 5'd10;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed table ----
        row.typed = -1;
        row.exp0 = '0;
        row.exp1 = '0;

        // run straight after reset: no points, both centroids at the origin
        row.it = make_item(kmc_pkg::OP_RUN, 0, 0, 0, 0);
        row.typed = 2;
        row.exp0 = make_report(0, 0, 0, 0, 0, 0, 1'b0);
        row.exp1 = make_report(1, 0, 0, 0, 0, 0, 1'b1);
        rows.push_back(row);

        // corner points sitting exactly on opposite corner centroids
        row.typed = -1;
        row.it = make_item(kmc_pkg::OP_SET, 0, 32767, 32767, 32767);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_SET, 1, -32768, -32768, -32768);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_LOAD, 0, -32768, -32768, -32768);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_LOAD, 0, 32767, 32767, 32767);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_RUN, 0, 0, 0, 0);
        row.typed = 2;
        row.exp0 = make_report(0, 32767, 32767, 32767, 1, 0, 1'b0);
        row.exp1 = make_report(1, -32768, -32768, -32768, 1, 0, 1'b1);
        rows.push_back(row);

        // tie between two identical centroids goes to the lower index
        row.typed = -1;
        row.it = make_item(kmc_pkg::OP_CLEAR, 0, 0, 0, 0);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_SET, 0, 0, 0, 0);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_SET, 1, 0, 0, 0);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_LOAD, 0, 5, 5, 5);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_RUN, 0, 0, 0, 0);
        row.typed = 2;
        row.exp0 = make_report(0, 5, 5, 5, 1, 0, 1'b0);
        row.exp1 = make_report(1, 0, 0, 0, 0, 0, 1'b1);
        rows.push_back(row);

        // cleared store: empty clusters keep their centroids
        row.typed = -1;
        row.it = make_item(kmc_pkg::OP_CLEAR, 3, -1, -1, -1);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_RUN, 7, 0, 0, 0);
        row.typed = 2;
        row.exp0 = make_report(0, 5, 5, 5, 0, 0, 1'b0);
        row.exp1 = make_report(1, 0, 0, 0, 0, 0, 1'b1);
        rows.push_back(row);

        // centroid above the count is stored but unused; negative means truncate to zero
        row.typed = -1;
        row.it = make_item(kmc_pkg::OP_SET, 7, -12345, 23456, -1);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_SET, 0, 100, -100, 7);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_LOAD, 0, -3, 4, -7);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_LOAD, 0, -2, 9, 30000);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_LOAD, 0, -32768, 32767, -20000);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_LOAD, 0, 1, 1, 1);
        rows.push_back(row);
        row.it = make_item(kmc_pkg::OP_RUN, 0, 0, 0, 0);
        rows.push_back(row);

        foreach (rows[i])
        begin
            push_item(rows[i].it);
            cluster_predict(rows[i].it);
            if (rows[i].typed < 0)
                foreach (fresh_reports[j])
                    expected_reports.push_back(fresh_reports[j]);
            else
            begin
                expected_reports.push_back(rows[i].exp0);
                expected_reports.push_back(rows[i].exp1);
            end
        end
        wait_drained();

        // centroid seven now in use, widest count and the raw extremes of both registers
        write_reg(kmc_pkg::REG_CLUSTER_COUNT, 15);
        write_reg(kmc_pkg::REG_PASS_COUNT, 31);
        send_predicted(make_item(kmc_pkg::OP_RUN, 0, 0, 0, 0));
        wait_drained();

        // count zero acts as one cluster, pass count zero as one pass
        write_reg(kmc_pkg::REG_CLUSTER_COUNT, 0);
        write_reg(kmc_pkg::REG_PASS_COUNT, 0);
        send_predicted(make_item(kmc_pkg::OP_CLEAR, 0, 0, 0, 0));
        for (int i = 0; i < 12; i++)
            send_predicted(make_item(kmc_pkg::OP_LOAD, 0, pick_coord(), pick_coord(),
                                     pick_coord()));
        send_predicted(make_item(kmc_pkg::OP_RUN, 0, 0, 0, 0));
        send_predicted(make_item(kmc_pkg::OP_CLEAR, 0, 0, 0, 0));
        wait_drained();

        // ---- random sequences: set up, load clustered points, run ----
        seq = 0;
        while (items_sent < ITEM_GOAL)
        begin
            case (seq % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            wait_drained();

            if ($urandom_range(9) == 0)
                write_reg(kmc_pkg::REG_CLUSTER_COUNT, $urandom_range(9, 15));
            else if ($urandom_range(9) == 0)
                write_reg(kmc_pkg::REG_CLUSTER_COUNT, 0);
            else
                write_reg(kmc_pkg::REG_CLUSTER_COUNT, $urandom_range(1, 8));
            if ($urandom_range(9) == 0)
                write_reg(kmc_pkg::REG_PASS_COUNT, $urandom_range(16, 31));
            else if ($urandom_range(9) == 0)
                write_reg(kmc_pkg::REG_PASS_COUNT, 0);
            else
                write_reg(kmc_pkg::REG_PASS_COUNT, $urandom_range(1, 4));
            k_eff = (cfg_k < 1) ? 1 :
                    (cfg_k > kmc_pkg::MAX_CLUSTERS) ? kmc_pkg::MAX_CLUSTERS : int'(cfg_k);

            // keep the store small so a run stays short
            if (npts > 30 || $urandom_range(2) == 0)
                send_predicted(make_item(kmc_pkg::OP_CLEAR, $urandom_range(7), pick_coord(),
                                         pick_coord(), pick_coord()));

            for (int c = 0; c < kmc_pkg::MAX_CLUSTERS; c++)
                if (c < k_eff || $urandom_range(3) == 0)
                    send_predicted(make_item(kmc_pkg::OP_SET, c, pick_coord(), pick_coord(),
                                             pick_coord()));

            n_new = $urandom_range(0, 10);
            cx = pick_coord();
            cy = pick_coord();
            cz = pick_coord();
            for (int i = 0; i < n_new; i++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    cx = pick_coord();
                    cy = pick_coord();
                    cz = pick_coord();
                end
                if ($urandom_range(9) == 0)
                    // noise in the middle of a sequence: a stray centroid write or clear
                    send_predicted(make_item($urandom_range(1) ? kmc_pkg::OP_SET
                                                               : kmc_pkg::OP_CLEAR,
                                             $urandom_range(7), pick_coord(), pick_coord(),
                                             pick_coord()));
                send_predicted(make_item(kmc_pkg::OP_LOAD, $urandom_range(7), near(cx),
                                         near(cy), near(cz)));
            end

            // mostly a run, now and then none, now and then two back to back
            if ($urandom_range(7) != 0)
                send_predicted(make_item(kmc_pkg::OP_RUN, $urandom_range(7), pick_coord(),
                                         pick_coord(), pick_coord()));
            if ($urandom_range(7) == 0)
                send_predicted(make_item(kmc_pkg::OP_RUN, 0, 0, 0, 0));
            seq++;
        end

        in_ch.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d items, %0d run items and %0d result beats over %0d sequences,",
                 items_sent, runs_sent, reports_seen, seq);
        $display("with ties, empty runs, cleared stores and register extremes; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("kmeans_cluster_engine_tb: PASS");
        else
            $display("kmeans_cluster_engine_tb: FAIL");
        $finish;
    end

endmodule
